@@ src/svf_pkg.sv @@
// svf_pkg: shared types and constants for the state-variable filter.
// Used by svf_ctrl, svf_datapath and state_variable_filter; no dependencies.

package svf_pkg;

   // Configuration port shape and register widths
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam int MODE_WIDTH      = 2;
   localparam int G_COEF_WIDTH    = 20;
   localparam int K_COEF_WIDTH    = 18;
   localparam int A1_COEF_WIDTH   = 17;

   // Guard fraction bits carried by the integrators below one sample LSB
   localparam int EXTRA_FRAC = 8;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FILTER_MODE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_G_COEF      = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_K_COEF      = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A1_COEF     = 4'd3;

   // Filter modes (the unused code behaves as lowpass)
   localparam logic [MODE_WIDTH-1:0] MODE_LOWPASS  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_HIGHPASS = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_BANDPASS = 2'd2;

   // Reset values of the registers
   localparam logic [MODE_WIDTH-1:0]    MODE_RESET = MODE_LOWPASS;
   localparam logic [G_COEF_WIDTH-1:0]  G_RESET    = 20'd10384;
   localparam logic [K_COEF_WIDTH-1:0]  K_RESET    = 18'd26214;
   localparam logic [A1_COEF_WIDTH-1:0] A1_RESET   = 17'd60211;

   // Operand pair for the shared multiplier
   typedef enum logic [2:0] {
      MUL_G_A1   = 3'd0,   // a2 = g * a1
      MUL_G_A2   = 3'd1,   // a3 = g * a2
      MUL_IC1_A1 = 3'd2,
      MUL_V3_A2  = 3'd3,
      MUL_IC1_A2 = 3'd4,
      MUL_V3_A3  = 3'd5,
      MUL_V1_K   = 3'd6
   } mul_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        accept;    // capture request sample, form v3
      mul_sel_type mul_sel;
      logic        ld_a2;     // latch capped g*a1
      logic        ld_a3;     // latch capped g*a2
      logic        v1_load;
      logic        v1_add;
      logic        v1_sat;
      logic        v2_load;
      logic        v2_add;
      logic        v2_sat;
      logic        ic1_upd;
      logic        hp_ld;
      logic        finish;    // update integrator two, load response register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

@@ src/svf_ctrl.sv @@
// svf_ctrl: sequencer that steps the shared multiplier through one request.
// Depends on svf_pkg for the command and status types.

module svf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  coef_change,
   input  svf_pkg::dp_status_type status,
   output svf_pkg::dp_cmd_type    cmd
);
   import svf_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_A2     = 10'b00_0000_0010,
      ST_A3     = 10'b00_0000_0100,
      ST_M1     = 10'b00_0000_1000,
      ST_M2     = 10'b00_0001_0000,
      ST_M3     = 10'b00_0010_0000,
      ST_M4     = 10'b00_0100_0000,
      ST_M5     = 10'b00_1000_0000,
      ST_M6     = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      dirty_ff, dirty_in;          // a2/a3 need recomputing
   logic      from_coef_ff, from_coef_in; // product in flight is g*a2

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      from_coef_in = 1'b0;
      cmd          = '0;
      cmd.mul_sel  = MUL_IC1_A1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = dirty_ff ? ST_A2 : ST_M1;
            end
         end
         ST_A2: begin
            cmd.mul_sel = MUL_G_A1;
            state_in    = ST_A3;
         end
         ST_A3: begin
            cmd.mul_sel  = MUL_G_A2;
            cmd.ld_a2    = 1'b1;
            from_coef_in = 1'b1;
            state_in     = ST_M1;
         end
         ST_M1: begin
            cmd.mul_sel = MUL_IC1_A1;
            cmd.ld_a3   = from_coef_ff;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.mul_sel = MUL_V3_A2;
            cmd.v1_load = 1'b1;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.mul_sel = MUL_IC1_A2;
            cmd.v1_add  = 1'b1;
            state_in    = ST_M4;
         end
         ST_M4: begin
            cmd.mul_sel = MUL_V3_A3;
            cmd.v2_load = 1'b1;
            cmd.v1_sat  = 1'b1;
            state_in    = ST_M5;
         end
         ST_M5: begin
            cmd.mul_sel = MUL_V1_K;
            cmd.v2_add  = 1'b1;
            cmd.ic1_upd = 1'b1;
            state_in    = ST_M6;
         end
         ST_M6: begin
            cmd.v2_sat = 1'b1;
            cmd.hp_ld  = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Coefficient refresh flag: set by g or a1 writes, cleared when a2 is formed
   always_comb begin
      dirty_in = dirty_ff;
      if (coef_change) begin
         dirty_in = 1'b1;
      end else if (state_ff == ST_A2) begin
         dirty_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b1;
         from_coef_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         from_coef_ff <= from_coef_in;
      end
   end

endmodule

@@ src/svf_datapath.sv @@
// svf_datapath: shared multiplier, accumulators, integrators and response register.
// Depends on svf_pkg; driven by svf_ctrl commands.

module svf_datapath #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 32,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  svf_pkg::dp_cmd_type                    cmd,
   output svf_pkg::dp_status_type                 status,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   input  logic [svf_pkg::MODE_WIDTH-1:0]         filter_mode,
   input  logic [svf_pkg::G_COEF_WIDTH-1:0]       g_coef,
   input  logic [svf_pkg::K_COEF_WIDTH-1:0]       k_coef,
   input  logic [svf_pkg::A1_COEF_WIDTH-1:0]      a1_coef,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out
);
   import svf_pkg::*;

   localparam int V0W = SAMPLE_WIDTH + EXTRA_FRAC;
   localparam int VW  = ((V0W > STATE_WIDTH) ? V0W : STATE_WIDTH) + 1;
   localparam int CW  = (COEF_FRAC_BITS + 3 > G_COEF_WIDTH + 1) ?
                        COEF_FRAC_BITS + 3 : G_COEF_WIDTH + 1;
   localparam int PW  = VW + CW;
   localparam int SHW = PW - COEF_FRAC_BITS;
   localparam int AW  = SHW + 2;
   localparam int YW  = AW - EXTRA_FRAC;
   localparam logic [SHW-1:0] A_CAP = SHW'(1) << (COEF_FRAC_BITS + 1);

   logic signed [V0W-1:0]         v0_ff, v0_in;
   logic signed [VW-1:0]          v3_ff, v3_in;
   logic signed [STATE_WIDTH-1:0] ic1_ff, ic1_in;
   logic signed [STATE_WIDTH-1:0] ic2_ff, ic2_in;
   logic [CW-1:0]                 a2_ff, a3_ff;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [AW-1:0]          v1acc_ff, v2acc_ff;
   logic signed [STATE_WIDTH-1:0] v1_ff, v2_ff;
   logic signed [SHW-1:0]         hp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;

   logic signed [VW-1:0]  mul_a;
   logic signed [CW-1:0]  mul_b;
   logic signed [SHW-1:0] prod_sh;
   logic [CW-1:0]         coef_capped;
   logic signed [AW-1:0]  y_full;
   logic signed [YW-1:0]  y_sh;

   // Saturate a wide value to the state width
   function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [AW-1:0] x);
      logic all_ones;
      logic all_zeros;
      all_ones  = &x[AW-1:STATE_WIDTH-1];
      all_zeros = ~|x[AW-1:STATE_WIDTH-1];
      if (all_ones || all_zeros) begin
         sat_state = x[STATE_WIDTH-1:0];
      end else if (x[AW-1]) begin
         sat_state = {1'b1, {(STATE_WIDTH-1){1'b0}}};
      end else begin
         sat_state = {1'b0, {(STATE_WIDTH-1){1'b1}}};
      end
   endfunction

   // Saturate the shifted output node to the sample width
   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [YW-1:0] x);
      logic all_ones;
      logic all_zeros;
      all_ones  = &x[YW-1:SAMPLE_WIDTH-1];
      all_zeros = ~|x[YW-1:SAMPLE_WIDTH-1];
      if (all_ones || all_zeros) begin
         sat_sample = x[SAMPLE_WIDTH-1:0];
      end else if (x[YW-1]) begin
         sat_sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         sat_sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   endfunction

   // Floored product and capped coefficient (a2, a3 are never negative)
   assign prod_sh     = SHW'(prod_ff >>> COEF_FRAC_BITS);
   assign coef_capped = ($unsigned(prod_sh) > A_CAP) ? CW'(A_CAP) : prod_sh[CW-1:0];

   // Multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_G_A1: begin
            mul_a = VW'(a1_coef);
            mul_b = CW'(g_coef);
         end
         MUL_G_A2: begin
            mul_a = VW'(g_coef);
            mul_b = coef_capped;
         end
         MUL_IC1_A1: begin
            mul_a = VW'(ic1_ff);
            mul_b = CW'(a1_coef);
         end
         MUL_V3_A2: begin
            mul_a = v3_ff;
            mul_b = a2_ff;
         end
         MUL_IC1_A2: begin
            mul_a = VW'(ic1_ff);
            mul_b = a2_ff;
         end
         MUL_V3_A3: begin
            mul_a = v3_ff;
            mul_b = a3_ff;
         end
         MUL_V1_K: begin
            mul_a = VW'(v1_ff);
            mul_b = CW'(k_coef);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // Sample capture and v3 = v0 - ic2
   assign v0_in = {req_sample_in, {EXTRA_FRAC{1'b0}}};
   assign v3_in = VW'(v0_in) - VW'(ic2_ff);

   // Output node select by mode
   always_comb begin
      case (filter_mode)
         MODE_HIGHPASS: y_full = AW'(v0_ff) - AW'(hp_ff) - AW'(v2_ff);
         MODE_BANDPASS: y_full = AW'(v1_ff);
         default:       y_full = AW'(v2_ff);
      endcase
   end

   assign y_sh          = YW'(y_full >>> EXTRA_FRAC);
   assign rsp_sample_in = sat_sample(y_sh);

   // Integrator updates: ic = sat(2*v - ic)
   assign ic1_in = sat_state(AW'(v1_ff) + AW'(v1_ff) - AW'(ic1_ff));
   assign ic2_in = sat_state(AW'(v2_ff) + AW'(v2_ff) - AW'(ic2_ff));

   // Response register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   // Control state and integrators
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ic1_ff       <= '0;
         ic2_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.ic1_upd) begin
            ic1_ff <= ic1_in;
         end
         if (cmd.finish) begin
            ic2_ff <= ic2_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.accept) begin
         v0_ff <= v0_in;
         v3_ff <= v3_in;
      end
      if (cmd.ld_a2) begin
         a2_ff <= coef_capped;
      end
      if (cmd.ld_a3) begin
         a3_ff <= coef_capped;
      end
      if (cmd.v1_load) begin
         v1acc_ff <= AW'(prod_sh);
      end else if (cmd.v1_add) begin
         v1acc_ff <= v1acc_ff + AW'(prod_sh);
      end
      if (cmd.v2_load) begin
         v2acc_ff <= AW'(ic2_ff) + AW'(prod_sh);
      end else if (cmd.v2_add) begin
         v2acc_ff <= v2acc_ff + AW'(prod_sh);
      end
      if (cmd.v1_sat) begin
         v1_ff <= sat_state(v1acc_ff);
      end
      if (cmd.v2_sat) begin
         v2_ff <= sat_state(v2acc_ff);
      end
      if (cmd.hp_ld) begin
         hp_ff <= prod_sh;
      end
      if (cmd.finish) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

endmodule

@@ src/state_variable_filter.sv @@
// state_variable_filter: top level of the trapezoidal state-variable filter.
// Holds the configuration registers; instantiates svf_ctrl and svf_datapath.
//
// Usage:
//  - req_valid/req_stall/req_sample_in carry one signed audio sample per request.
//    A request is taken when req_valid is high and req_stall is low.
//  - rsp_valid/rsp_stall/rsp_sample_out return one filtered, saturated sample
//    per request, in order.
//  - csr_write_enable/csr_index/csr_wdata write the mode (0), g (1), k (2) and
//    a1 (3) registers; other indexes are ignored. Write only while idle.
//  - After a write to g or a1, the next request first rebuilds a2 = g*a1 and
//    a3 = g*a2. A new request is taken only once the previous one is done.
//    Five products go through one shared multiplier, one per cycle, followed
//    by the output step, and the response is registered.
//  - While rsp_stall holds a response, the next request is taken and worked
//    on, then waits in its last step until the response register frees.
//  - Reset clears both integrators and restores the register reset values.

module state_variable_filter #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int STATE_WIDTH    = 32,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_sample_out,
   input  logic                                  csr_write_enable,
   input  logic [svf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [svf_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import svf_pkg::*;

   logic [MODE_WIDTH-1:0]    mode_ff, mode_in;
   logic [G_COEF_WIDTH-1:0]  g_ff, g_in;
   logic [K_COEF_WIDTH-1:0]  k_ff, k_in;
   logic [A1_COEF_WIDTH-1:0] a1_ff, a1_in;
   logic                     coef_change;
   dp_cmd_type               cmd;
   dp_status_type            status;

   // Configuration register writes
   always_comb begin
      mode_in = mode_ff;
      g_in    = g_ff;
      k_in    = k_ff;
      a1_in   = a1_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_FILTER_MODE: mode_in = csr_wdata[MODE_WIDTH-1:0];
            REG_G_COEF:      g_in    = csr_wdata[G_COEF_WIDTH-1:0];
            REG_K_COEF:      k_in    = csr_wdata[K_COEF_WIDTH-1:0];
            REG_A1_COEF:     a1_in   = csr_wdata[A1_COEF_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // g or a1 changed: a2 and a3 must be rebuilt before the next request
   assign coef_change = csr_write_enable &&
                        ((csr_index == REG_G_COEF) || (csr_index == REG_A1_COEF));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         g_ff    <= G_RESET;
         k_ff    <= K_RESET;
         a1_ff   <= A1_RESET;
      end else begin
         mode_ff <= mode_in;
         g_ff    <= g_in;
         k_ff    <= k_in;
         a1_ff   <= a1_in;
      end
   end

   svf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .coef_change (coef_change),
      .status      (status),
      .cmd         (cmd)
   );

   svf_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .STATE_WIDTH    (STATE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .filter_mode    (mode_ff),
      .g_coef         (g_ff),
      .k_coef         (k_ff),
      .a1_coef        (a1_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

@@ test/state_variable_filter_tb.sv @@
// state_variable_filter_tb: self-checking testbench for the state-variable filter.
// Drives samples and register writes into state_variable_filter, predicts every
// response with its own fixed-point filter model; needs svf_pkg and the RTL only.
`timescale 1ns / 1ps

module state_variable_filter_tb;
   import svf_pkg::*;

   localparam int SAMPLE_W    = 16;
   localparam int STATE_W     = 32;
   localparam int COEF_FRAC   = 16;
   localparam int NUM_REGS    = 4;
   localparam int ITEM_TARGET = 1450;
   localparam int SETTLE_CYC  = 12;      // quiet gap before register writes
   localparam int DRAIN_LIMIT = 20000;
   localparam int MAX_PRINTS  = 100;
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Filter model state and its copy of the registers
   logic [MODE_WIDTH-1:0] flt_mode = MODE_RESET;
   longint coef_g = longint'(G_RESET);
   longint coef_k = longint'(K_RESET);
   longint coef_a1 = longint'(A1_RESET);
   longint integ_one = 0;
   longint integ_two = 0;

   logic signed [SAMPLE_W-1:0] expected_samples[$];
   int samples_sent = 0;
   int results_checked = 0;
   int error_count = 0;

   // Sender and receiver pacing
   int burst_left = 0;
   bit gaps_on = 1'b0;
   int stall_pct = 0;
   int stall_run = 0;
   int hold_off_cycles = 0;

   state_variable_filter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Fixed-point filter model
   // ---------------------------------------------------------------------
   function automatic longint clamp_width(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -(longint'(1) <<< (w - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // floor(x * c / 2^F); the product stays well inside 64 bits
   function automatic longint scale_by_coef(longint x, longint c);
      return (x * c) >>> COEF_FRAC;
   endfunction

   // Advances both integrators and returns the filtered sample
   function automatic logic signed [SAMPLE_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] x);
      longint cap, a2, a3, v0, v1, v2, v3, ic1, ic2, y;
      cap = longint'(1) <<< (COEF_FRAC + 1);
      a2 = (coef_g * coef_a1) >>> COEF_FRAC;
      if (a2 > cap) a2 = cap;
      a3 = (coef_g * a2) >>> COEF_FRAC;
      if (a3 > cap) a3 = cap;
      ic1 = integ_one;
      ic2 = integ_two;
      v0 = longint'(x) * (longint'(1) <<< EXTRA_FRAC);
      v3 = v0 - ic2;
      v1 = clamp_width(scale_by_coef(ic1, coef_a1) + scale_by_coef(v3, a2), STATE_W);
      v2 = clamp_width(ic2 + scale_by_coef(ic1, a2) + scale_by_coef(v3, a3), STATE_W);
      integ_one = clamp_width(2 * v1 - ic1, STATE_W);
      integ_two = clamp_width(2 * v2 - ic2, STATE_W);
      if (flt_mode == MODE_HIGHPASS) y = v0 - scale_by_coef(v1, coef_k) - v2;
      else if (flt_mode == MODE_BANDPASS) y = v1;
      else y = v2;   // lowpass, also the unused mode code
      y = clamp_width(y >>> EXTRA_FRAC, SAMPLE_W);
      return y[SAMPLE_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Reporting and response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("response %0d (%0d) with no request outstanding",
                                      results_checked, rsp_sample_out));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_out !== want)
               report_mismatch($sformatf("response %0d: sample_out %0d, predicted %0d",
                                         results_checked, rsp_sample_out, want));
         end
         results_checked++;
      end
   end

   // Receiver: long hold-off when asked, otherwise random stall runs
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
         rsp_stall <= 1'b1;
         stall_run = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   function automatic logic [CSR_DATA_WIDTH-1:0] field_mask(logic [CSR_INDEX_WIDTH-1:0] idx);
      case (idx)
         REG_FILTER_MODE: return CSR_DATA_WIDTH'((1 << MODE_WIDTH) - 1);
         REG_G_COEF:      return CSR_DATA_WIDTH'((1 << G_COEF_WIDTH) - 1);
         REG_K_COEF:      return CSR_DATA_WIDTH'((1 << K_COEF_WIDTH) - 1);
         REG_A1_COEF:     return CSR_DATA_WIDTH'((1 << A1_COEF_WIDTH) - 1);
         default:         return '1;
      endcase
   endfunction

   // One register write; half the time junk rides above the field width
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] data;
      data = value;
      if ($urandom_range(0, 1)) data = data | (CSR_DATA_WIDTH'($urandom) & ~field_mask(idx));
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_FILTER_MODE: flt_mode = data[MODE_WIDTH-1:0];
         REG_G_COEF:      coef_g = longint'(data[G_COEF_WIDTH-1:0]);
         REG_K_COEF:      coef_k = longint'(data[K_COEF_WIDTH-1:0]);
         REG_A1_COEF:     coef_a1 = longint'(data[A1_COEF_WIDTH-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_unused_reg();
      write_reg(CSR_INDEX_WIDTH'($urandom_range(NUM_REGS, (1 << CSR_INDEX_WIDTH) - 1)),
                CSR_DATA_WIDTH'($urandom));
   endtask

   task automatic write_setting(logic [MODE_WIDTH-1:0] mode, longint g, longint k, longint a1);
      write_reg(REG_FILTER_MODE, CSR_DATA_WIDTH'(mode));
      write_reg(REG_G_COEF, CSR_DATA_WIDTH'(g));
      write_reg(REG_K_COEF, CSR_DATA_WIDTH'(k));
      write_reg(REG_A1_COEF, CSR_DATA_WIDTH'(a1));
   endtask

   // Sensible coefficients: a1 = 1/(1+g*(g+k)) as software would compute it
   task automatic write_sane_setting(logic [MODE_WIDTH-1:0] mode);
      longint g, k, a1;
      g = longint'($urandom_range(16, 200000));
      k = longint'($urandom_range(0, 131072));
      a1 = (longint'(1) <<< 32) / (65536 + ((g * (g + k)) >>> COEF_FRAC));
      if (a1 > 65536) a1 = 65536;
      write_setting(mode, g, k, a1);
   endtask

   // Present one request; the model steps when the block takes it
   task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_samples.push_back(filter_sample(s));
      samples_sent++;
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_sample_in <= SAMPLE_W'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_in_bursts(logic signed [SAMPLE_W-1:0] s);
      if (burst_left == 0) begin
         if (gaps_on) pause_sender($urandom_range(1, 12));
         burst_left = $urandom_range(1, 24);
      end
      send_sample(s);
      burst_left--;
   endtask

   // Stop sending and wait for every outstanding response
   task automatic wait_all_returned();
      int waited;
      waited = 0;
      pause_sender(1);
      while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d requests never answered", expected_samples.size()));
         expected_samples.delete();
      end
   endtask

   task automatic settle_idle();
      wait_all_returned();
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_values();
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh5555);
   endtask

   // Every mode, including the unused code, with writes to unused indexes
   task automatic test_filter_modes();
      logic [MODE_WIDTH-1:0] modes[4];
      modes = '{MODE_LOWPASS, MODE_HIGHPASS, MODE_BANDPASS, MODE_UNUSED};
      foreach (modes[i]) begin
         settle_idle();
         write_unused_reg();
         write_reg(REG_FILTER_MODE, CSR_DATA_WIDTH'(modes[i]));
         send_sample(16'sh7FFF);
         send_sample(16'sh8000);
      end
   endtask

   // Full-scale coefficients drive a2/a3 and the nodes into saturation; then zero and small-g settings
   task automatic test_coef_extremes();
      settle_idle();
      write_setting(MODE_HIGHPASS, (longint'(1) <<< G_COEF_WIDTH) - 1,
                    (longint'(1) <<< K_COEF_WIDTH) - 1,
                    (longint'(1) <<< A1_COEF_WIDTH) - 1);
      send_sample(16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'shAAAA);
      settle_idle();
      write_setting(MODE_BANDPASS, 0, 0, 0);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      settle_idle();
      write_setting(MODE_HIGHPASS, 1, 131072, 65536);
      send_sample(16'sh8000);
   endtask

   // Receiver holds off while requests keep coming: the block must fill up
   task automatic test_backpressure();
      settle_idle();
      write_sane_setting(MODE_BANDPASS);
      hold_off_cycles = 300;
      repeat (40) send_sample(SAMPLE_W'($urandom));
   endtask

   // Sender stops mid-stream until every response is back
   task automatic test_drain_pause();
      gaps_on = 1'b1;
      stall_pct = 30;
      repeat (12) send_in_bursts(SAMPLE_W'($urandom));
      wait_all_returned();
      repeat (12) send_in_bursts(SAMPLE_W'($urandom));
   endtask

   // Random settings, signal shapes and pacing, one phase at a time
   task automatic test_random_phases();
      int len, shape, half, kind, n;
      logic [MODE_WIDTH-1:0] mode;
      logic signed [SAMPLE_W-1:0] s;
      longint g, k, a1;
      while (samples_sent < ITEM_TARGET) begin
         settle_idle();
         if ($urandom_range(0, 3) == 0) write_unused_reg();
         mode = MODE_WIDTH'($urandom_range(0, 3));
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            write_sane_setting(mode);
         end else begin
            case ($urandom_range(0, 3))
               0: g = 0;
               1: g = (longint'(1) <<< G_COEF_WIDTH) - 1;
               2: g = 1;
               default: g = longint'($urandom_range(0, (1 << G_COEF_WIDTH) - 1));
            endcase
            case ($urandom_range(0, 3))
               0: k = 0;
               1: k = 131072;
               2: k = (longint'(1) <<< K_COEF_WIDTH) - 1;
               default: k = longint'($urandom_range(0, (1 << K_COEF_WIDTH) - 1));
            endcase
            case ($urandom_range(0, 3))
               0: a1 = 0;
               1: a1 = 65536;
               2: a1 = (longint'(1) <<< A1_COEF_WIDTH) - 1;
               default: a1 = longint'($urandom_range(0, (1 << A1_COEF_WIDTH) - 1));
            endcase
            write_setting(mode, g, k, a1);
         end
         // pacing for this phase; some phases run without any idling
         gaps_on = $urandom_range(0, 2) != 0;
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 30;
            default: stall_pct = 60;
         endcase
         burst_left = 0;
         len = $urandom_range(30, 120);
         shape = $urandom_range(0, 3);
         half = $urandom_range(4, 40);
         for (n = 0; n < len; n++) begin
            case (shape)
               0: s = SAMPLE_W'($urandom);
               1: s = SAMPLE_W'($urandom_range(0, 1023) - 512);
               2: s = ((n / half) % 2) ? 16'sh7FFF : 16'sh8000;
               default: begin
                  case ($urandom_range(0, 3))
                     0: s = 16'sh7FFF;
                     1: s = 16'sh8000;
                     2: s = 16'sh0000;
                     default: s = SAMPLE_W'($urandom);
                  endcase
               end
            endcase
            send_in_bursts(s);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_filter_modes();
      test_coef_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_phases();

      // let the last responses come back, then idle before reporting
      stall_pct = 0;
      wait_all_returned();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
